// ----- rtl/crc8wd_pkg.sv -----
`default_nettype none

package crc8wd_pkg;

  localparam int MaxWords = 3;

  localparam int ByteW    = 8;
  localparam int WordW    = 16;
  localparam int ConvW    = 17;
  localparam int StatusW  = 2;
  localparam int IdxW     = 2;
  localparam int WprW     = 2;
  localparam int ModeW    = 3;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 3;
  localparam int OutDataW = 40;

  localparam logic [7:0] CrcPoly = 8'h31;
  localparam logic [7:0] CrcInit = 8'hFF;

  localparam logic [WprW-1:0] WprReset = 2'd3;

  // config register indexes
  localparam logic [CfgIdxW-1:0] RegWords = 1'd0;
  localparam logic [CfgIdxW-1:0] RegMode  = 1'd1;

  // conversion modes
  localparam logic [ModeW-1:0] ModeRaw    = 3'd0;
  localparam logic [ModeW-1:0] ModeMeas   = 3'd1;
  localparam logic [ModeW-1:0] ModeOffset = 3'd2;
  localparam logic [ModeW-1:0] ModeEqOne  = 3'd3;
  localparam logic [ModeW-1:0] ModeReady  = 3'd4;

  // word status
  localparam logic [StatusW-1:0] StatGood  = 2'd0;
  localparam logic [StatusW-1:0] StatBad   = 2'd1;
  localparam logic [StatusW-1:0] StatAbort = 2'd2;

  // byte position within a group
  localparam logic [1:0] PhHigh = 2'd0;
  localparam logic [1:0] PhLow  = 2'd1;
  localparam logic [1:0] PhCrc  = 2'd2;

  // word positions in measurement mode
  localparam logic [IdxW-1:0] IdxTemp = 2'd1;
  localparam logic [IdxW-1:0] IdxHum  = 2'd2;

  localparam logic [23:0] TempScale  = 24'd175;
  localparam logic [22:0] HumScale   = 23'd100;
  localparam logic [ConvW-1:0] TempOffset = 17'd45;
  localparam logic [11:0] ReadyMask  = 12'hFFF;

  // MSB-first CRC-8 update over one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/crc8wd_convert.sv -----
`default_nettype none

module crc8wd_convert
  import crc8wd_pkg::*;
(
  input  wire logic [ModeW-1:0]  mode_i,
  input  wire logic [IdxW-1:0]   idx_i,
  input  wire logic [WordW-1:0]  raw_i,
  output logic signed [ConvW-1:0] value_o
);

  logic [23:0]      p175;
  logic [22:0]      p100;
  logic [7:0]       t175;
  logic [6:0]       h100;
  logic [ConvW-1:0] temp_c;
  logic [ConvW-1:0] raw_x;

  assign p175   = 24'(raw_i) * TempScale;
  assign p100   = 23'(raw_i) * HumScale;
  assign t175   = p175[23:16];
  assign h100   = p100[22:16];
  assign temp_c = {9'd0, t175} - TempOffset;
  assign raw_x  = {1'b0, raw_i};

  always_comb begin
    unique case (mode_i)
      ModeMeas: begin
        if (idx_i == IdxTemp) begin
          value_o = $signed(temp_c);
        end else if (idx_i == IdxHum) begin
          value_o = $signed({10'd0, h100});
        end else begin
          value_o = $signed(raw_x);
        end
      end
      ModeOffset: value_o = $signed({9'd0, t175});
      ModeEqOne:  value_o = $signed({16'd0, (raw_i == 16'd1)});
      ModeReady:  value_o = $signed({16'd0, ((raw_i[11:0] & ReadyMask) != 12'd0)});
      default:    value_o = $signed(raw_x);
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/crc8_word_response_deframer_top.sv -----
// CRC-8 word response deframer.
// Slave stream: one received byte per item in s_axis_tdata_i; s_axis_tuser_i
// marks the first byte of a response and restarts byte, word and CRC tracking.
// Every third byte closes a word (high byte, low byte, CRC-8 poly 0x31, init
// 0xFF). That item produces one master item: raw word, converted value, status
// and word index in m_axis_tdata_o, last word of the response on m_axis_tlast_o.
// Other bytes produce no item. Once a CRC fails, the remaining words of that
// response carry the aborted status.
// Latency: the master item is valid the cycle after its CRC byte is accepted.
// Throughput: one byte per cycle, set by the single register stage holding
// the output item. If the receiver stalls with an item held, the byte that
// follows a word's low byte waits, whether it is a CRC byte or a response
// start, until the held item leaves or is taken in the same cycle; other
// bytes are still taken.
// Config: cfg index 0 words per response (0 acts as 1), index 1 conversion
// mode; write only while idle. cfg_ready_o is always high.
// Reset: words per response 3, mode raw, counters cleared, no output item.
`default_nettype none

module crc8_word_response_deframer_top
  import crc8wd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  wire logic [ByteW-1:0]     s_axis_tdata_i,   // [7:0] rx_byte
  input  wire logic                 s_axis_tuser_i,   // [0] response_start
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // [15:0] raw_word, [32:16] converted_value, [34:33] status,
  // [36:35] word_index, [39:37] zero
  output logic [OutDataW-1:0]       m_axis_tdata_o,
  output logic                      m_axis_tlast_o,   // last_word
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i
);

  logic [WprW-1:0]  wpr_q;
  logic [ModeW-1:0] mode_q;

  logic [1:0]       phase_q, phase_d;
  logic [IdxW-1:0]  wcnt_q, wcnt_d;
  logic [7:0]       crc_q, crc_d;
  logic             abort_q, abort_d;
  logic [WordW-1:0] hold_q, hold_d;

  logic             out_valid_q, out_valid_d;
  logic [WordW-1:0] out_raw_q;
  logic [ConvW-1:0] out_conv_q;
  logic [StatusW-1:0] out_stat_q, stat_c;
  logic [IdxW-1:0]  out_idx_q;
  logic             out_last_q, last_c;

  logic             accept;
  logic             emit;
  logic [1:0]       phase_e;
  logic [IdxW-1:0]  wcnt_e;
  logic [7:0]       crc_e;
  logic             abort_e;
  logic [3:0]       n_eff;
  logic signed [ConvW-1:0] conv_c;

  assign cfg_ready_o = 1'b1;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i || (phase_q != PhCrc);
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    if (wpr_q == 2'd0) begin
      n_eff = 4'd1;
    end else if (4'(wpr_q) > 4'(MaxWords)) begin
      n_eff = 4'(MaxWords);
    end else begin
      n_eff = 4'(wpr_q);
    end
  end

  always_comb begin
    phase_e = s_axis_tuser_i ? PhHigh : phase_q;
    wcnt_e  = s_axis_tuser_i ? 2'd0 : wcnt_q;
    crc_e   = s_axis_tuser_i ? CrcInit : crc_q;
    abort_e = s_axis_tuser_i ? 1'b0 : abort_q;

    phase_d = phase_e;
    wcnt_d  = wcnt_e;
    crc_d   = crc_e;
    abort_d = abort_e;
    hold_d  = hold_q;
    emit    = 1'b0;
    last_c  = (4'(wcnt_e) + 4'd1) >= n_eff;
    stat_c  = StatGood;

    unique case (phase_e)
      PhLow: begin
        hold_d  = {hold_q[15:8], s_axis_tdata_i};
        crc_d   = crc8_byte(crc_e, s_axis_tdata_i);
        phase_d = PhCrc;
      end
      PhCrc: begin
        emit = 1'b1;
        if (abort_e) begin
          stat_c = StatAbort;
        end else if (crc_e == s_axis_tdata_i) begin
          stat_c = StatGood;
        end else begin
          stat_c  = StatBad;
          abort_d = 1'b1;
        end
        phase_d = PhHigh;
        crc_d   = CrcInit;
        if (last_c) begin
          wcnt_d  = 2'd0;
          abort_d = 1'b0;
        end else begin
          wcnt_d = wcnt_e + 2'd1;
        end
      end
      default: begin
        hold_d  = {s_axis_tdata_i, hold_q[7:0]};
        crc_d   = crc8_byte(crc_e, s_axis_tdata_i);
        phase_d = PhLow;
      end
    endcase
  end

  crc8wd_convert u_convert (
    .mode_i  (mode_q),
    .idx_i   (wcnt_e),
    .raw_i   (hold_q),
    .value_o (conv_c)
  );

  always_comb begin
    if (accept && emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpr_q       <= WprReset;
      mode_q      <= ModeRaw;
      phase_q     <= PhHigh;
      wcnt_q      <= 2'd0;
      crc_q       <= CrcInit;
      abort_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == RegWords) begin
          wpr_q <= cfg_data_i[WprW-1:0];
        end else if (cfg_index_i == RegMode) begin
          mode_q <= cfg_data_i;
        end
      end
      if (accept) begin
        phase_q <= phase_d;
        wcnt_q  <= wcnt_d;
        crc_q   <= crc_d;
        abort_q <= abort_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hold_q <= hold_d;
    end
    if (accept && emit) begin
      out_raw_q  <= hold_q;
      out_conv_q <= conv_c;
      out_stat_q <= stat_c;
      out_idx_q  <= wcnt_e;
      out_last_q <= last_c;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'd0, out_idx_q, out_stat_q, out_conv_q, out_raw_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
`default_nettype none

module tb;
  import crc8wd_pkg::*;

  localparam int unsigned NumPhases  = 20;
  localparam int unsigned PhaseItems = 92;
  localparam int unsigned CycleLimit = 600000;

  typedef struct {
    logic [7:0] b;
    logic       start;
  } rx_item_t;

  typedef struct {
    logic [WordW-1:0]   raw;
    logic [ConvW-1:0]   conv;
    logic [StatusW-1:0] status;
    logic [IdxW-1:0]    idx;
    logic               is_last;
  } word_result_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                s_valid   = 1'b0;
  logic [ByteW-1:0]    s_data    = '0;
  logic                s_user    = 1'b0;
  logic                m_ready   = 1'b0;
  logic                cfg_valid = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  logic                s_axis_tready_o;
  logic                m_axis_tvalid_o;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                m_axis_tlast_o;
  logic                cfg_ready_o;

  crc8_word_response_deframer_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  rx_item_t     rx_pending[$];
  rx_item_t     next_rx;
  word_result_t expected_words[$];

  // predictor state and register copies
  logic [WprW-1:0]  words_cfg = WprReset;
  logic [ModeW-1:0] mode_cfg  = ModeRaw;
  logic [1:0]       grp_phase = PhHigh;
  logic [1:0]       word_pos  = '0;
  logic [7:0]       crc_run   = CrcInit;
  logic [15:0]      word_hold = '0;
  logic             in_abort  = 1'b0;

  bit          calm       = 1'b0;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  int unsigned cycles     = 0;
  int unsigned errors     = 0;
  int unsigned bytes_sent = 0;
  int unsigned words_seen = 0;
  int unsigned bad_seen   = 0;
  int unsigned abort_seen = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      if (r[7] ^ b[i]) begin
        r = {r[6:0], 1'b0} ^ 8'h31;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    return r;
  endfunction

  function automatic logic [ConvW-1:0] scaled_value(input logic [15:0] raw,
                                                    input logic [1:0] pos);
    int unsigned t175;
    int unsigned t100;
    t175 = (32'(raw) * 175) >> 16;
    t100 = (32'(raw) * 100) >> 16;
    case (mode_cfg)
      ModeMeas: begin
        if (pos == IdxTemp) return ConvW'(int'(t175) - 45);
        if (pos == IdxHum) return ConvW'(t100);
        return ConvW'(raw);
      end
      ModeOffset: return ConvW'(t175);
      ModeEqOne:  return (raw == 16'd1) ? ConvW'(1) : ConvW'(0);
      ModeReady:  return (raw[11:0] != 12'd0) ? ConvW'(1) : ConvW'(0);
      default:    return ConvW'(raw);
    endcase
  endfunction

  function automatic void deframe_byte(input logic [7:0] b, input logic start);
    word_result_t r;
    int unsigned  n;
    if (start) begin
      grp_phase = PhHigh;
      word_pos  = '0;
      crc_run   = CrcInit;
      in_abort  = 1'b0;
    end
    if (grp_phase == PhLow) begin
      word_hold[7:0] = b;
      crc_run = crc_step(crc_run, b);
      grp_phase = PhCrc;
    end else if (grp_phase != PhCrc) begin
      word_hold[15:8] = b;
      crc_run = crc_step(crc_run, b);
      grp_phase = PhLow;
    end else begin
      n = (words_cfg == 0) ? 1 : ((words_cfg > MaxWords) ? MaxWords : words_cfg);
      r.raw     = word_hold;
      r.idx     = word_pos;
      r.is_last = (int'(word_pos) + 1 >= n);
      if (in_abort) begin
        r.status = StatAbort;
      end else if (crc_run == b) begin
        r.status = StatGood;
      end else begin
        r.status = StatBad;
        in_abort = 1'b1;
      end
      r.conv = scaled_value(word_hold, word_pos);
      expected_words.push_back(r);
      grp_phase = PhHigh;
      crc_run   = CrcInit;
      if (r.is_last) begin
        word_pos = '0;
        in_abort = 1'b0;
      end else begin
        word_pos = word_pos + 1'b1;
      end
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h0001;
      3:       return {4'($urandom_range(0, 15)), 12'h000};
      4:       return 16'($urandom_range(0, 20000));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic void push_byte(input logic [7:0] b, input logic start);
    rx_item_t it;
    it.b     = b;
    it.start = start;
    rx_pending.push_back(it);
  endfunction

  // one word group; corrupt flips the check byte
  function automatic void push_word(input logic [15:0] w, input logic start,
                                    input bit corrupt);
    logic [7:0] c;
    c = crc_step(crc_step(CrcInit, w[15:8]), w[7:0]);
    if (corrupt) c = c ^ 8'($urandom_range(1, 255));
    push_byte(w[15:8], start);
    push_byte(w[7:0], 1'b0);
    push_byte(c, 1'b0);
  endfunction

  function automatic void push_response(input int unsigned nw, input logic start,
                                        input int unsigned err_pct);
    for (int unsigned i = 0; i < nw; i++) begin
      push_word(pick_word(), start && (i == 0), $urandom_range(0, 99) < err_pct);
    end
  endfunction

  task automatic wait_idle();
    while (rx_pending.size() != 0 || s_valid || expected_words.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == RegWords) begin
      words_cfg = val[WprW-1:0];
    end else begin
      mode_cfg = val[ModeW-1:0];
    end
    cfg_valid <= 1'b0;
  endtask

  // byte source
  always @(posedge clk_i) begin
    if (!rst_n) begin
      s_valid <= 1'b0;
    end else begin
      if (s_valid && s_axis_tready_o) begin
        deframe_byte(s_data, s_user);
        bytes_sent++;
      end
      if (!s_valid || s_axis_tready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          s_valid <= 1'b0;
        end else if (rx_pending.size() > 0) begin
          next_rx = rx_pending.pop_front();
          s_valid <= 1'b1;
          s_data  <= next_rx.b;
          s_user  <= next_rx.start;
          gap_left = pick_gap();
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // word sink and checker
  always @(posedge clk_i) begin
    word_result_t e;
    if (!rst_n) begin
      m_ready <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_ready) begin
        if (expected_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected item tdata=%h tlast=%b", $time,
                   m_axis_tdata_o, m_axis_tlast_o);
        end else begin
          e = expected_words.pop_front();
          words_seen++;
          if (e.status == StatBad) bad_seen++;
          if (e.status == StatAbort) abort_seen++;
          if (m_axis_tdata_o[15:0] !== e.raw || m_axis_tdata_o[32:16] !== e.conv ||
              m_axis_tdata_o[34:33] !== e.status || m_axis_tdata_o[36:35] !== e.idx ||
              m_axis_tdata_o[39:37] !== 3'b000 || m_axis_tlast_o !== e.is_last) begin
            errors++;
            $display("%0t: expected raw=%h conv=%h status=%0d idx=%0d last=%b pad=0", $time,
                     e.raw, e.conv, e.status, e.idx, e.is_last);
            $display("%0t: actual   raw=%h conv=%h status=%0d idx=%0d last=%b pad=%0d", $time,
                     m_axis_tdata_o[15:0], m_axis_tdata_o[32:16], m_axis_tdata_o[34:33],
                     m_axis_tdata_o[36:35], m_axis_tlast_o, m_axis_tdata_o[39:37]);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout, %0d words still expected", $time, expected_words.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int unsigned eff;
    int unsigned mark;
    int unsigned r;
    logic [1:0]  wsel;
    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;

    // reset settings: three words, raw
    push_word(16'h0000, 1'b1, 1'b0);
    push_word(16'hFFFF, 1'b0, 1'b0);
    push_word(16'hBEEF, 1'b0, 1'b0);
    push_word(16'h1234, 1'b1, 1'b0);
    push_word(16'h5678, 1'b0, 1'b1);
    push_word(16'h9ABC, 1'b0, 1'b0);
    push_word(16'h0001, 1'b0, 1'b0);
    push_byte(8'hA5, 1'b0);
    push_byte(8'h5A, 1'b0);
    push_word(16'h8000, 1'b1, 1'b0);
    wait_idle();

    for (int unsigned k = 1; k <= NumPhases; k++) begin
      if (k == 1) wsel = 2'd3;
      else if (k % 5 == 2) wsel = 2'd0;
      else if (k % 5 == 3) wsel = 2'd3;
      else wsel = 2'($urandom_range(0, 3));
      write_reg(RegWords, {1'($urandom_range(0, 1)), wsel});
      write_reg(RegMode, CfgDataW'(k % 8));
      calm = (k % 4 == 0);
      eff  = (wsel == 0) ? 1 : wsel;
      mark = rx_pending.size();
      while (rx_pending.size() - mark < PhaseItems) begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          push_response(eff, $urandom_range(0, 99) < 80, 15);
        end else if (r < 88) begin
          push_response($urandom_range(1, 3), $urandom_range(0, 1), 20);
        end else begin
          repeat ($urandom_range(1, 5)) begin
            push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 99) < 30);
          end
        end
      end
      wait_idle();
    end

    calm = 1'b0;
    repeat (5) @(posedge clk_i);
    $display("Sent %0d bytes over %0d register settings; checked %0d words", bytes_sent,
             NumPhases + 1, words_seen);
    $display("Words with a bad check byte: %0d, aborted words: %0d", bad_seen, abort_seen);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
